[hdl/array_list_insert_delete_search_assert.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the array list block
// Shorthand for clocked implication checks with reset masking.
// ---------------------------------------------------------------------------
`ifndef ARRAY_LIST_INSERT_DELETE_SEARCH_ASSERT_SVH
`define ARRAY_LIST_INSERT_DELETE_SEARCH_ASSERT_SVH

// Same-cycle implication.
`define ALIDS_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ALIDS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/alids_pkg.sv]
// ---------------------------------------------------------------------------
// alids_pkg
// Types and constants shared by the array list cells, sequencer and top.
// ---------------------------------------------------------------------------
package alids_pkg;

    localparam int CAPACITY_DEF = 512;
    localparam int KEY_W        = 32;
    localparam int PAY_W        = 32;
    localparam int POS_W        = 10;
    localparam int FOUND_W      = 9;
    localparam int COUNT_W      = 10;

    typedef enum logic [2:0] {
        REQ_PUSH   = 3'd0,
        REQ_INSERT = 3'd1,
        REQ_POP    = 3'd2,
        REQ_READ   = 3'd3,
        REQ_SEARCH = 3'd4
    } req_kind_t;

    typedef enum logic [2:0] {
        STS_OK       = 3'd0,
        STS_FULL     = 3'd1,
        STS_EMPTY    = 3'd2,
        STS_BADPOS   = 3'd3,
        STS_NOTFOUND = 3'd4
    } status_t;

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } state_t;

    typedef struct packed {
        req_kind_t                 req_type;
        logic signed [KEY_W-1:0]   key_in;
        logic        [PAY_W-1:0]   payload_in;
        logic        [POS_W-1:0]   position;
    } req_beat_t;

    typedef struct packed {
        status_t                   status;
        logic        [FOUND_W-1:0] found_position;
        logic signed [KEY_W-1:0]   key_out;
        logic        [PAY_W-1:0]   payload_out;
        logic        [COUNT_W-1:0] entry_count;
    } rsp_beat_t;

    typedef struct packed {
        logic rotate;
        logic shift_up;
        logic load;
    } cell_ctl_t;

endpackage

[hdl/array_list_insert_delete_search.sv]
// ---------------------------------------------------------------------------
// array_list_insert_delete_search
// Fixed-capacity ordered record list built as a ring of storage cells with
// a request sequencer: push, insert, pop, read by position, key search.
//
//   channel | dir | handshake           | beat
//   --------+-----+---------------------+-----------
//   req     | in  | req_valid/req_stall | req_beat_t
//   rsp     | out | rsp_valid/rsp_stall | rsp_beat_t
//
// Push, insert, pop, failed requests and unused codes are answered from idle.
// Read and search: the cell ring rotates one full turn past the head cell,
// which the sequencer inspects each cycle; new requests stall meanwhile.
// Reset clears the fill count and control only; cell contents are undefined.
// A pending response beat blocks new requests only while rsp_stall is high.
// ---------------------------------------------------------------------------
module array_list_insert_delete_search
    import alids_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_stall,
    input  req_beat_t req,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    output rsp_beat_t rsp
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    cell_ctl_t         cell_ctl;
    logic [CNT_W-1:0]  tgt;
    logic [KEY_W-1:0]  wr_key;
    logic [PAY_W-1:0]  wr_pay;
    logic [KEY_W-1:0]  ring_key [CAPACITY];
    logic [PAY_W-1:0]  ring_pay [CAPACITY];

    alids_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .head_key  (ring_key[0]),
        .head_pay  (ring_pay[0]),
        .cell_ctl  (cell_ctl),
        .tgt       (tgt),
        .wr_key    (wr_key),
        .wr_pay    (wr_pay)
    );

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        localparam int UP = (i + 1) % CAPACITY;
        localparam int DN = (i + CAPACITY - 1) % CAPACITY;

        alids_cell #(
            .CAPACITY (CAPACITY),
            .IDX      (i)
        ) u_cell (
            .clk      (clk),
            .ctl      (cell_ctl),
            .tgt      (tgt),
            .wr_key   (wr_key),
            .wr_pay   (wr_pay),
            .up_key   (ring_key[UP]),
            .up_pay   (ring_pay[UP]),
            .dn_key   (ring_key[DN]),
            .dn_pay   (ring_pay[DN]),
            .cell_key (ring_key[i]),
            .cell_pay (ring_pay[i])
        );
    end

endmodule

[hdl/alids_cell.sv]
// ---------------------------------------------------------------------------
// alids_cell
// One list slot: holds a key and payload, rotates toward the head, shifts
// up on insert, or loads new data when addressed.
// ---------------------------------------------------------------------------
module alids_cell
    import alids_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF,
    parameter int IDX      = 0
)
(
    input  logic                               clk,
    input  cell_ctl_t                          ctl,
    input  logic [$clog2(CAPACITY + 1) - 1:0]  tgt,
    input  logic [KEY_W-1:0]                   wr_key,
    input  logic [PAY_W-1:0]                   wr_pay,
    input  logic [KEY_W-1:0]                   up_key,
    input  logic [PAY_W-1:0]                   up_pay,
    input  logic [KEY_W-1:0]                   dn_key,
    input  logic [PAY_W-1:0]                   dn_pay,
    output logic [KEY_W-1:0]                   cell_key,
    output logic [PAY_W-1:0]                   cell_pay
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(IDX);

    logic [KEY_W-1:0] key_reg;
    logic [KEY_W-1:0] key_next;
    logic [PAY_W-1:0] pay_reg;
    logic [PAY_W-1:0] pay_next;

    always_comb
    begin
        key_next = key_reg;
        pay_next = pay_reg;
        if (ctl.rotate)
        begin
            key_next = up_key;
            pay_next = up_pay;
        end
        else if (ctl.load && (MY_IDX == tgt))
        begin
            key_next = wr_key;
            pay_next = wr_pay;
        end
        else if (ctl.shift_up && (MY_IDX > tgt))
        begin
            key_next = dn_key;
            pay_next = dn_pay;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        pay_reg <= pay_next;
    end

    assign cell_key = key_reg;
    assign cell_pay = pay_reg;

endmodule

[hdl/alids_ctrl.sv]
// ---------------------------------------------------------------------------
// alids_ctrl
// Request sequencer: fill count, scan stepping over the rotating cell ring,
// and the registered response beat.
// ---------------------------------------------------------------------------
`include "array_list_insert_delete_search_assert.svh"

module alids_ctrl
    import alids_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               req_valid,
    output logic                               req_stall,
    input  req_beat_t                          req,
    output logic                               rsp_valid,
    input  logic                               rsp_stall,
    output rsp_beat_t                          rsp,
    input  logic [KEY_W-1:0]                   head_key,
    input  logic [PAY_W-1:0]                   head_pay,
    output cell_ctl_t                          cell_ctl,
    output logic [$clog2(CAPACITY + 1) - 1:0]  tgt,
    output logic [KEY_W-1:0]                   wr_key,
    output logic [PAY_W-1:0]                   wr_pay
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = $clog2(CAPACITY);
    localparam logic [CNT_W-1:0] CAP_CNT  = CNT_W'(CAPACITY);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [IDX_W-1:0]  step_reg, step_next;
    logic              hit_reg, hit_next;
    logic              rsp_valid_reg, rsp_valid_next;
    req_kind_t         op_reg, op_next;
    logic [KEY_W-1:0]  key_reg, key_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [IDX_W-1:0]  found_reg, found_next;
    logic [KEY_W-1:0]  rkey_reg, rkey_next;
    logic [PAY_W-1:0]  rpay_reg, rpay_next;
    rsp_beat_t         rsp_reg, rsp_next;

    logic              accept;
    logic              full;
    logic              start_scan;
    logic              scan_last;
    logic [31:0]       cnt32;
    logic [31:0]       pos32;
    logic [31:0]       step32;
    logic [31:0]       spos32;
    logic [31:0]       cnt_out32;
    logic [31:0]       found32;
    rsp_beat_t         res;

    assign req_stall = !((state_reg == ST_IDLE) && (!rsp_valid_reg || !rsp_stall));
    assign accept    = req_valid && !req_stall;
    assign full      = (count_reg == CAP_CNT);
    assign scan_last = (state_reg == ST_SCAN) && (step_reg == LAST_IDX);
    assign cnt32     = 32'(count_reg);
    assign pos32     = 32'(req.position);
    assign step32    = 32'(step_reg);
    assign spos32    = 32'(pos_reg);

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        step_next      = step_reg;
        hit_next       = hit_reg;
        op_next        = op_reg;
        key_next       = key_reg;
        pos_next       = pos_reg;
        found_next     = found_reg;
        rkey_next      = rkey_reg;
        rpay_next      = rpay_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        cell_ctl       = '0;
        tgt            = count_reg;
        wr_key         = req.key_in;
        wr_pay         = req.payload_in;
        start_scan     = 1'b0;
        res            = '0;
        res.status     = STS_OK;
        cnt_out32      = '0;
        found32        = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (req.req_type)
                        REQ_PUSH:
                        begin
                            if (full)
                            begin
                                res.status = STS_FULL;
                            end
                            else
                            begin
                                cell_ctl.load = 1'b1;
                                count_next    = count_reg + 1'b1;
                            end
                        end
                        REQ_INSERT:
                        begin
                            if (full)
                            begin
                                res.status = STS_FULL;
                            end
                            else if (pos32 > cnt32)
                            begin
                                res.status = STS_BADPOS;
                            end
                            else
                            begin
                                cell_ctl.load     = 1'b1;
                                cell_ctl.shift_up = 1'b1;
                                tgt               = CNT_W'(pos32);
                                count_next        = count_reg + 1'b1;
                            end
                        end
                        REQ_POP:
                        begin
                            if (count_reg == '0)
                            begin
                                res.status = STS_EMPTY;
                            end
                            else
                            begin
                                count_next = count_reg - 1'b1;
                            end
                        end
                        REQ_READ:
                        begin
                            if (pos32 >= cnt32)
                            begin
                                res.status = STS_BADPOS;
                            end
                            else
                            begin
                                start_scan = 1'b1;
                            end
                        end
                        REQ_SEARCH:
                        begin
                            if (count_reg == '0)
                            begin
                                res.status = STS_NOTFOUND;
                            end
                            else
                            begin
                                start_scan = 1'b1;
                            end
                        end
                        default:
                        begin
                            res.status = STS_OK;
                        end
                    endcase

                    if (start_scan)
                    begin
                        state_next = ST_SCAN;
                        step_next  = '0;
                        hit_next   = 1'b0;
                        found_next = '0;
                        rkey_next  = '0;
                        rpay_next  = '0;
                        op_next    = req.req_type;
                        key_next   = req.key_in;
                        pos_next   = req.position;
                    end
                    else
                    begin
                        cnt_out32       = 32'(count_next);
                        res.entry_count = cnt_out32[COUNT_W-1:0];
                        rsp_next        = res;
                        rsp_valid_next  = 1'b1;
                    end
                end
            end
            ST_SCAN:
            begin
                cell_ctl.rotate = 1'b1;
                if ((op_reg == REQ_READ) && (step32 == spos32))
                begin
                    rkey_next = head_key;
                    rpay_next = head_pay;
                end
                if ((op_reg == REQ_SEARCH) && !hit_reg && (step32 < cnt32)
                    && (head_key == key_reg))
                begin
                    hit_next   = 1'b1;
                    found_next = step_reg;
                end

                if (step_reg == LAST_IDX)
                begin
                    state_next      = ST_IDLE;
                    cnt_out32       = 32'(count_reg);
                    found32         = 32'(found_next);
                    res.entry_count = cnt_out32[COUNT_W-1:0];
                    if (op_reg == REQ_READ)
                    begin
                        res.key_out     = $signed(rkey_next);
                        res.payload_out = rpay_next;
                    end
                    else if (hit_next)
                    begin
                        res.found_position = found32[FOUND_W-1:0];
                    end
                    else
                    begin
                        res.status = STS_NOTFOUND;
                    end
                    rsp_next       = res;
                    rsp_valid_next = 1'b1;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            step_reg      <= '0;
            hit_reg       <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            step_reg      <= step_next;
            hit_reg       <= hit_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        key_reg   <= key_next;
        pos_reg   <= pos_next;
        found_reg <= found_next;
        rkey_reg  <= rkey_next;
        rpay_reg  <= rpay_next;
        rsp_reg   <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    `ALIDS_ASSERT_IMPL(a_count_max, 1'b1, count_reg <= CAP_CNT, "fill count above capacity")
    `ALIDS_ASSERT_IMPL(a_scan_rsp_free, state_reg == ST_SCAN, !rsp_valid_reg, "early response")
    `ALIDS_ASSERT_NEXT(a_count_hold, !accept, $stable(count_reg), "count moved without a beat")
    `ALIDS_ASSERT_NEXT(a_scan_end, scan_last, rsp_valid_reg, "scan end without response")

endmodule

[verif/testbench.sv]
// ----------------------------------------------------------------------------
// Array list request/response testbench
// Sends push, insert, pop, read and search requests with random idle cycles
// on the request side and random stalls on the response side. A mirror of
// the list gives the expected response beat for each accepted request, and
// every field of every response beat is compared in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
    import alids_pkg::*;

    localparam int CAP      = CAPACITY_DEF;
    localparam int ITEMS    = 1170;
    localparam int HOLD_AT  = 60;
    localparam int HOLD_LEN = 1500;
    localparam logic [KEY_W-1:0] KEY_TAIL = 32'h2468_ACE1;

    typedef struct {
        req_beat_t beat;
        bit        drain_first;
    } queued_req_t;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      req_valid = 1'b0;
    logic      req_stall;
    req_beat_t req       = '0;
    logic      rsp_valid;
    logic      rsp_stall = 1'b0;
    rsp_beat_t rsp;

    queued_req_t             requests_to_send[$];
    rsp_beat_t               list_results_due[$];
    logic signed [KEY_W-1:0] mirror_key[CAP];
    logic        [PAY_W-1:0] mirror_payload[CAP];
    int                      mirror_count = 0;
    int                      gen_count    = 0;
    logic        [KEY_W-1:0] recent_keys[$];
    int                      n_items      = 0;
    int                      n_accepted   = 0;
    int                      n_checked    = 0;
    int                      n_errors     = 0;
    int                      hold_left    = 0;
    bit                      hold_armed   = 1'b1;
    int unsigned             idle_left    = 0;
    int unsigned             calm_beats   = 0;
    int unsigned             stall_left   = 0;
    int unsigned             calm_cycles  = 0;

    array_list_insert_delete_search #(
        .CAPACITY(CAP)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .req(req),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp(rsp)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic rsp_beat_t apply_to_list(input req_beat_t r);
        rsp_beat_t o;
        int        i;
        o        = '0;
        o.status = STS_OK;
        case (r.req_type)
            REQ_PUSH:
                if (mirror_count >= CAP)
                    o.status = STS_FULL;
                else
                begin
                    mirror_key[mirror_count]     = r.key_in;
                    mirror_payload[mirror_count] = r.payload_in;
                    mirror_count++;
                end
            REQ_INSERT:
                if (mirror_count >= CAP)
                    o.status = STS_FULL;
                else if (int'(r.position) > mirror_count)
                    o.status = STS_BADPOS;
                else
                begin
                    for (i = mirror_count; i > int'(r.position); i--)
                    begin
                        mirror_key[i]     = mirror_key[i-1];
                        mirror_payload[i] = mirror_payload[i-1];
                    end
                    mirror_key[r.position]     = r.key_in;
                    mirror_payload[r.position] = r.payload_in;
                    mirror_count++;
                end
            REQ_POP:
                if (mirror_count == 0)
                    o.status = STS_EMPTY;
                else
                    mirror_count--;
            REQ_READ:
                if (int'(r.position) >= mirror_count)
                    o.status = STS_BADPOS;
                else
                begin
                    o.key_out     = mirror_key[r.position];
                    o.payload_out = mirror_payload[r.position];
                end
            REQ_SEARCH:
            begin
                o.status = STS_NOTFOUND;
                for (i = 0; i < mirror_count && o.status == STS_NOTFOUND; i++)
                    if (mirror_key[i] == r.key_in)
                    begin
                        o.status         = STS_OK;
                        o.found_position = i[FOUND_W-1:0];
                    end
            end
            default:
                ;
        endcase
        o.entry_count = mirror_count[COUNT_W-1:0];
        return o;
    endfunction

    function automatic int unsigned pick_idle();
        int unsigned roll;
        roll = $urandom_range(99, 0);
        if (roll < 55)
            return 0;
        if (roll < 85)
            return $urandom_range(3, 1);
        if (roll < 97)
            return $urandom_range(12, 4);
        return $urandom_range(60, 20);
    endfunction

    function automatic logic [KEY_W-1:0] pick_key();
        case ($urandom_range(9, 0))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            4:       return 32'h5555_5555;
            5:       return 32'hAAAA_AAAA;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [PAY_W-1:0] pick_payload();
        case ($urandom_range(9, 0))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic void add_req(input req_kind_t kind, input logic [KEY_W-1:0] key,
                                    input logic [PAY_W-1:0] pay,
                                    input logic [POS_W-1:0] pos, input bit drain);
        queued_req_t q;
        q.beat.req_type   = kind;
        q.beat.key_in     = key;
        q.beat.payload_in = pay;
        q.beat.position   = pos;
        q.drain_first     = drain;
        requests_to_send.push_back(q);
        case (kind)
            REQ_PUSH:
                if (gen_count < CAP)
                    gen_count++;
            REQ_INSERT:
                if (gen_count < CAP && int'(pos) <= gen_count)
                    gen_count++;
            REQ_POP:
                if (gen_count != 0)
                    gen_count--;
            default:
                ;
        endcase
        if (kind == REQ_PUSH || kind == REQ_INSERT)
        begin
            recent_keys.push_back(key);
            if (recent_keys.size() > 8)
                recent_keys.delete(0);
        end
    endfunction

    function automatic void gen_op(input int unsigned w_push, w_ins, w_pop, w_read,
                                   w_find, w_junk);
        int unsigned      roll;
        logic [POS_W-1:0] pos;
        logic [KEY_W-1:0] key;
        req_kind_t        kind;
        roll = $urandom_range(w_push + w_ins + w_pop + w_read + w_find + w_junk - 1, 0);
        pos  = POS_W'($urandom);
        key  = pick_key();
        if (roll < w_push)
            kind = REQ_PUSH;
        else if (roll < w_push + w_ins)
        begin
            kind = REQ_INSERT;
            case ($urandom_range(9, 0))
                0:       pos = '0;
                1:       pos = POS_W'(gen_count);
                2:       pos = POS_W'($urandom_range(1023, gen_count + 1));
                default: pos = POS_W'($urandom_range(gen_count, 0));
            endcase
        end
        else if (roll < w_push + w_ins + w_pop)
            kind = REQ_POP;
        else if (roll < w_push + w_ins + w_pop + w_read)
        begin
            kind = REQ_READ;
            if (gen_count != 0 && $urandom_range(4, 0) != 0)
                pos = POS_W'($urandom_range(gen_count - 1, 0));
            else
                pos = POS_W'($urandom_range(1023, gen_count));
        end
        else if (roll < w_push + w_ins + w_pop + w_read + w_find)
        begin
            kind = REQ_SEARCH;
            if ($urandom_range(4, 0) < 2 && recent_keys.size() != 0)
                key = recent_keys[$urandom_range(recent_keys.size() - 1, 0)];
            else if ($urandom_range(4, 0) == 0)
                key = $urandom;
        end
        else
            kind = req_kind_t'(3'($urandom_range(7, 5)));
        add_req(kind, key, pick_payload(), pos, 1'b0);
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] due);
        if (n_errors < 100)
            $display("%0t beat %0d: %s is %h, expected %h", $time, n_checked, what, got, due);
        n_errors++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : send_requests
        bit took;
        if (!rst_n)
        begin
            req_valid    <= 1'b0;
            req          <= '0;
            n_accepted   <= 0;
            mirror_count  = 0;
            idle_left     = 0;
            calm_beats    = 0;
        end
        else
        begin
            took = req_valid && !req_stall;
            if (took)
            begin
                list_results_due.push_back(apply_to_list(req));
                n_accepted <= n_accepted + 1;
                if (calm_beats != 0)
                    calm_beats--;
                else if ($urandom_range(15, 0) == 0)
                    calm_beats = 40;
                idle_left = (calm_beats != 0) ? 0 : pick_idle();
            end
            // hold a stalled beat; otherwise idle or advance
            if (!req_valid || took)
            begin
                if (idle_left != 0)
                begin
                    idle_left--;
                    req_valid <= 1'b0;
                end
                else if (requests_to_send.size() != 0 &&
                         !(requests_to_send[0].drain_first &&
                           (took || n_accepted != n_checked)))
                begin
                    req       <= requests_to_send[0].beat;
                    req_valid <= 1'b1;
                    requests_to_send.delete(0);
                end
                else
                    req_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left  <= 0;
            hold_armed <= 1'b1;
        end
        else if (hold_armed && n_accepted >= HOLD_AT)
        begin
            hold_left  <= HOLD_LEN;
            hold_armed <= 1'b0;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    always @(posedge clk or negedge rst_n)
    begin : check_results
        rsp_beat_t want;
        if (!rst_n)
        begin
            rsp_stall  <= 1'b0;
            n_checked  <= 0;
            stall_left  = 0;
            calm_cycles = 0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (n_checked == n_accepted)
                    report_mismatch("unexpected beat, entry_count", 32'(rsp.entry_count), '0);
                else
                begin
                    want = list_results_due.pop_front();
                    if (rsp.status !== want.status)
                        report_mismatch("status", 32'(rsp.status), 32'(want.status));
                    if (rsp.found_position !== want.found_position)
                        report_mismatch("found_position", 32'(rsp.found_position),
                                        32'(want.found_position));
                    if (rsp.key_out !== want.key_out)
                        report_mismatch("key_out", rsp.key_out, want.key_out);
                    if (rsp.payload_out !== want.payload_out)
                        report_mismatch("payload_out", rsp.payload_out, want.payload_out);
                    if (rsp.entry_count !== want.entry_count)
                        report_mismatch("entry_count", 32'(rsp.entry_count),
                                        32'(want.entry_count));
                    n_checked <= n_checked + 1;
                end
            end
            if (calm_cycles != 0)
                calm_cycles--;
            else if ($urandom_range(1999, 0) == 0)
                calm_cycles = 300;
            if (hold_left != 0)
                rsp_stall <= 1'b1;
            else if (stall_left != 0)
            begin
                stall_left--;
                rsp_stall <= 1'b1;
            end
            else
            begin
                rsp_stall <= 1'b0;
                if (calm_cycles == 0 && $urandom_range(3, 0) == 0)
                    stall_left = pick_idle();
            end
        end
    end

    initial
    begin
        add_req(REQ_POP,    $urandom,     $urandom,     10'd0,    1'b0);
        add_req(REQ_READ,   $urandom,     $urandom,     10'd0,    1'b0);
        add_req(REQ_SEARCH, 32'h0,        $urandom,     POS_W'($urandom), 1'b0);
        add_req(REQ_INSERT, $urandom,     $urandom,     10'd1,    1'b0);
        add_req(REQ_INSERT, 32'h8000_0000, 32'hFFFF_FFFF, 10'd0,  1'b0);
        add_req(REQ_PUSH,   32'h7FFF_FFFF, 32'h0,       10'd0,    1'b0);
        add_req(REQ_INSERT, 32'hFFFF_FFFF, 32'hA5A5_A5A5, 10'd1,  1'b0);
        add_req(REQ_INSERT, 32'h7FFF_FFFF, 32'h1,       10'd3,    1'b0);
        add_req(REQ_INSERT, $urandom,     $urandom,     10'd5,    1'b0);
        add_req(REQ_INSERT, $urandom,     $urandom,     10'd1023, 1'b0);
        add_req(REQ_READ,   $urandom,     $urandom,     10'd0,    1'b0);
        add_req(REQ_READ,   $urandom,     $urandom,     10'd3,    1'b0);
        add_req(REQ_READ,   $urandom,     $urandom,     10'd4,    1'b0);
        add_req(REQ_READ,   $urandom,     $urandom,     10'd1023, 1'b0);
        add_req(REQ_SEARCH, 32'h7FFF_FFFF, $urandom,    POS_W'($urandom), 1'b0);
        add_req(REQ_SEARCH, 32'h0,        $urandom,     POS_W'($urandom), 1'b0);
        add_req(REQ_SEARCH, 32'h8000_0000, $urandom,    POS_W'($urandom), 1'b0);
        add_req(req_kind_t'(3'd5), $urandom, $urandom,  POS_W'($urandom), 1'b0);
        add_req(req_kind_t'(3'd6), $urandom, $urandom,  POS_W'($urandom), 1'b0);
        add_req(req_kind_t'(3'd7), $urandom, $urandom,  POS_W'($urandom), 1'b0);
        add_req(REQ_POP,    $urandom,     $urandom,     POS_W'($urandom), 1'b0);
        add_req(REQ_READ,   $urandom,     $urandom,     10'd3,    1'b0);
        add_req(REQ_SEARCH, 32'hFFFF_FFFF, $urandom,    POS_W'($urandom), 1'b1);

        repeat (250)
            gen_op(20, 20, 15, 20, 20, 5);
        while (gen_count < CAP - 1)
            gen_op(40, 45, 3, 6, 6, 0);
        add_req(REQ_PUSH,   KEY_TAIL,     pick_payload(), POS_W'($urandom), 1'b1);
        add_req(REQ_PUSH,   pick_key(),   pick_payload(), POS_W'($urandom), 1'b0);
        add_req(REQ_INSERT, pick_key(),   pick_payload(), 10'd0,    1'b0);
        add_req(REQ_INSERT, pick_key(),   pick_payload(), 10'd1023, 1'b0);
        add_req(REQ_READ,   $urandom,     $urandom,       10'd511,  1'b0);
        add_req(REQ_READ,   $urandom,     $urandom,       10'd512,  1'b0);
        add_req(REQ_SEARCH, KEY_TAIL,     $urandom,       POS_W'($urandom), 1'b0);
        repeat (60)
            gen_op(20, 20, 25, 15, 15, 5);
        while (requests_to_send.size() < ITEMS)
            gen_op(5, 5, 55, 15, 15, 5);
        n_items = requests_to_send.size();

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        while (n_accepted != n_items)
            @(posedge clk);
        while (n_checked != n_items)
            @(posedge clk);
        repeat (CAP + 20) @(posedge clk);
        if (n_errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        #8_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

[files.f]
+incdir+hdl
hdl/alids_pkg.sv
hdl/alids_cell.sv
hdl/alids_ctrl.sv
hdl/array_list_insert_delete_search.sv
verif/testbench.sv
